### design/tbiw_pkg.sv
package tbiw_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;   // power of two, pointers wrap freely
  localparam int SLOT_W          = 4;
  localparam int VALUE_W         = 18;
  localparam int ENTRIES_W       = 5;
  localparam int OFFSET_W        = 16;
  localparam int WEIGHT_W        = 17;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 1;
  localparam int DIV_STEPS       = 17;
  localparam int DIV_CNT_W       = 5;
  localparam int DIFF_W          = VALUE_W + 1;

  localparam logic [WEIGHT_W-1:0] Q16_ONE = 17'h10000;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUND_OFFSET  = 1'd1;

  typedef enum logic [0:0] {
    CMD_QUERY = 1'b0,
    CMD_LOAD  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

### design/tbiw_front.sv
module tbiw_front #(
  parameter int TABLE_DEPTH = tbiw_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                       item_valid,
  output logic                                       item_stall,
  input  logic                                       operation,
  input  logic [tbiw_pkg::SLOT_W-1:0]                entry_slot,
  input  logic signed [tbiw_pkg::VALUE_W-1:0]        entry_value,
  input  logic signed [tbiw_pkg::VALUE_W-1:0]        query_value,
  input  logic                                       q_full,
  output logic                                       push,
  output tbiw_pkg::cmd_t                             push_cmd
);
  import tbiw_pkg::*;

  localparam int CMP_W = 9;

  cmd_kind_t kind;
  logic      slot_ok;

  assign kind    = cmd_kind_t'(operation);
  assign slot_ok = CMP_W'(entry_slot) < CMP_W'(TABLE_DEPTH);

  assign item_stall = q_full;

  // loads beyond the table are taken and dropped here
  assign push = item_valid && !q_full && (kind == CMD_QUERY || slot_ok);

  always_comb begin
    push_cmd.kind  = kind;
    push_cmd.slot  = entry_slot;
    push_cmd.value = (kind == CMD_LOAD) ? entry_value : query_value;
  end

endmodule

### design/tbiw_queue.sv
module tbiw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tbiw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output tbiw_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import tbiw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/tbiw_back.sv
module tbiw_back #(
  parameter int TABLE_DEPTH = tbiw_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [tbiw_pkg::ENTRIES_W-1:0]     entries_in_use,
  input  logic [tbiw_pkg::OFFSET_W-1:0]      ground_offset,
  input  logic                               q_empty,
  input  tbiw_pkg::cmd_t                     q_cmd,
  output logic                               pop,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [tbiw_pkg::SLOT_W-1:0]        table_slot,
  output logic [tbiw_pkg::OFFSET_W-1:0]      point_index,
  output logic [tbiw_pkg::WEIGHT_W-1:0]      weight,
  output logic                               last_flag
);
  import tbiw_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = 9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLASS,
    ST_DIV,
    ST_EMIT_FIRST,
    ST_EMIT_LAST
  } state_t;

  state_t                    state;
  logic signed [VALUE_W-1:0] cos_mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] mem_q;
  logic [IDX_W-1:0]          rd_addr;
  logic [IDX_W-1:0]          n_last;
  logic [IDX_W-1:0]          cmp_idx;
  logic [IDX_W-1:0]          up_slot;
  logic [IDX_W-1:0]          low_slot;
  logic [IDX_W-1:0]          em_slot;
  logic [WEIGHT_W-1:0]       em_weight;
  logic signed [VALUE_W-1:0] x;
  logic signed [VALUE_W-1:0] prev;
  logic signed [VALUE_W-1:0] vu;
  logic signed [VALUE_W-1:0] vl;
  logic [DIFF_W-1:0]         rem;
  logic [DIFF_W-1:0]         den;
  logic [WEIGHT_W-1:0]       quot;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic [DIFF_W-1:0]         num_next;
  logic [DIFF_W-1:0]         den_next;
  logic [DIFF_W-1:0]         trial;
  logic                      step_bit;
  logic [DIFF_W-1:0]         rem_next;
  logic                      out_free;
  logic                      found;
  logic                      emit_now;

  // zero entries acts as one, counts past the table saturate
  always_comb begin
    if (entries_in_use == '0) begin
      n_last = '0;
    end else if (CMP_W'(entries_in_use) > CMP_W'(TABLE_DEPTH)) begin
      n_last = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      n_last = IDX_W'(CMP_W'(entries_in_use) - CMP_W'(1));
    end
  end

  assign pop      = (state == ST_IDLE) && !q_empty;
  assign out_free = !result_valid || !result_stall;
  assign found    = (mem_q > x) || (cmp_idx == n_last);
  assign emit_now = (state == ST_EMIT_FIRST || state == ST_EMIT_LAST) && out_free;

  always_comb begin
    if (state == ST_SCAN && cmp_idx != n_last) begin
      rd_addr = cmp_idx + 1'b1;
    end else begin
      rd_addr = '0;
    end
  end

  assign num_next = {x[VALUE_W-1], x} - {vl[VALUE_W-1], vl};
  assign den_next = {vu[VALUE_W-1], vu} - {vl[VALUE_W-1], vl};

  // restoring divide, integer bit first then sixteen fraction bits
  assign trial    = (div_cnt == '0) ? rem : {rem[DIFF_W-2:0], 1'b0};
  assign step_bit = trial >= den;
  assign rem_next = step_bit ? trial - den : trial;

  always_ff @(posedge clk) begin
    if (pop && q_cmd.kind == CMD_LOAD) begin
      cos_mem[IDX_W'(q_cmd.slot)] <= q_cmd.value;
    end
    mem_q <= cos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty && q_cmd.kind == CMD_QUERY) begin
            x       <= q_cmd.value;
            cmp_idx <= '0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (found) begin
            up_slot  <= cmp_idx;
            low_slot <= (cmp_idx == '0) ? '0 : cmp_idx - 1'b1;
            vu       <= mem_q;
            vl       <= (cmp_idx == '0) ? mem_q : prev;
            state    <= ST_CLASS;
          end else begin
            prev    <= mem_q;
            cmp_idx <= cmp_idx + 1'b1;
          end
        end
        ST_CLASS: begin
          em_weight <= Q16_ONE;
          if (vu == vl) begin
            em_slot <= low_slot;
            state   <= ST_EMIT_LAST;
          end else if (x > vu) begin
            em_slot <= up_slot;
            state   <= ST_EMIT_LAST;
          end else if (x < vl) begin
            em_slot <= '0;
            state   <= ST_EMIT_LAST;
          end else begin
            rem     <= num_next;
            den     <= den_next;
            quot    <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem     <= rem_next;
          quot    <= {quot[WEIGHT_W-2:0], step_bit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= ST_EMIT_FIRST;
          end
        end
        ST_EMIT_FIRST: begin
          if (out_free) begin
            table_slot   <= SLOT_W'(up_slot);
            point_index  <= ground_offset + OFFSET_W'(up_slot);
            weight       <= quot;
            last_flag    <= 1'b0;
            em_slot      <= low_slot;
            em_weight    <= Q16_ONE - quot;
            state        <= ST_EMIT_LAST;
          end
        end
        ST_EMIT_LAST: begin
          if (out_free) begin
            table_slot   <= SLOT_W'(em_slot);
            point_index  <= ground_offset + OFFSET_W'(em_slot);
            weight       <= em_weight;
            last_flag    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> weight <= Q16_ONE)
    else $error("weight above one");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> cmp_idx <= n_last)
    else $error("scan beyond valid entries");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != '0) |-> rem < den)
    else $error("divider remainder not reduced");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_flag) |-> state == ST_EMIT_LAST)
    else $error("first result of a pair without its partner pending");

endmodule

### design/table_bracket_interp_weights.sv
// Piecewise-linear interpolation weights over an ascending table of Q16 cosines.
// Requests enter a two-entry queue, so the input side keeps taking requests
// while the back end works or a result waits, until the queue is full. A load
// is written to the table as it leaves the queue; a load to a slot beyond the
// table is taken and dropped. A query walks the table one entry per cycle
// through the memory read port until the first entry above it or the last
// entry in use, then passes a classify state. A bracketed query runs the
// one-bit-per-cycle divider and hands out two results; a query that falls
// outside or on equal neighbours gives one result after scan and classify.
// Table contents are undefined until loaded.
module table_bracket_interp_weights #(
  parameter int TABLE_DEPTH = tbiw_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [tbiw_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [tbiw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   operation,
  input  logic [tbiw_pkg::SLOT_W-1:0]            entry_slot,
  input  logic signed [tbiw_pkg::VALUE_W-1:0]    entry_value,
  input  logic signed [tbiw_pkg::VALUE_W-1:0]    query_value,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [tbiw_pkg::SLOT_W-1:0]            table_slot,
  output logic [tbiw_pkg::OFFSET_W-1:0]          point_index,
  output logic [tbiw_pkg::WEIGHT_W-1:0]          weight,
  output logic                                   last_flag
);
  import tbiw_pkg::*;

  logic [ENTRIES_W-1:0] entries_in_use;
  logic [OFFSET_W-1:0]  ground_offset;
  logic                 push;
  cmd_t                 push_cmd;
  logic                 q_full;
  logic                 q_empty;
  logic                 pop;
  cmd_t                 q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_W'(1);
      ground_offset  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENTRIES_IN_USE: entries_in_use <= cfg_data[ENTRIES_W-1:0];
        REG_GROUND_OFFSET:  ground_offset  <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  tbiw_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .operation   (operation),
    .entry_slot  (entry_slot),
    .entry_value (entry_value),
    .query_value (query_value),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  tbiw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  tbiw_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .entries_in_use (entries_in_use),
    .ground_offset  (ground_offset),
    .q_empty        (q_empty),
    .q_cmd          (q_cmd),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .table_slot     (table_slot),
    .point_index    (point_index),
    .weight         (weight),
    .last_flag      (last_flag)
  );

endmodule
